FILE: src/tali_pkg.sv
// ----------------------------------------------------------------------------
// tali_pkg
// shared types and constants of the two-axis line interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package tali_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int STEPS_BITS         = 16;
	localparam int CFG_INDEX_BITS     = 1;
	localparam int S_TDATA_BITS       = 8;
	localparam int S_TUSER_BITS       = 1;
	localparam int M_TDATA_BITS       = 8;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PULSE = 1'b1
	} opcode_t;

	typedef enum logic {
		AXIS_X = 1'b0,
		AXIS_Y = 1'b1
	} axis_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_STEPS_X = 1'b0,
		REG_STEPS_Y = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		opcode_t opcode;
		axis_t   pulse_axis;
		logic    stop_request;
	} item_t;

	// status of one decision carried alongside the products
	typedef struct packed {
		logic stop;
		logic x_open;
		logic y_open;
	} flags_t;

endpackage

`default_nettype wire

FILE: src/tali_step_counter.sv
// ----------------------------------------------------------------------------
// tali_step_counter
// saturating step counters of both axes, cleared by a start request
// ----------------------------------------------------------------------------
`default_nettype none

module tali_step_counter #(
	parameter int COUNT_BITS = tali_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire tali_pkg::item_t       item,
	output logic      [COUNT_BITS-1:0] done_x,
	output logic      [COUNT_BITS-1:0] done_y
);

	logic [COUNT_BITS-1:0] done_x_q;
	logic [COUNT_BITS-1:0] done_y_q;
	logic                  x_full;
	logic                  y_full;

	assign x_full = &done_x_q;
	assign y_full = &done_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_x_q <= '0;
			done_y_q <= '0;
		end else if (take) begin
			if (item.opcode == tali_pkg::OP_START) begin
				done_x_q <= '0;
				done_y_q <= '0;
			end else if (item.pulse_axis == tali_pkg::AXIS_X) begin
				if (!x_full) begin
					done_x_q <= done_x_q + COUNT_BITS'(1);
				end
			end else begin
				if (!y_full) begin
					done_y_q <= done_y_q + COUNT_BITS'(1);
				end
			end
		end
	end

	assign done_x = done_x_q;
	assign done_y = done_y_q;

endmodule

`default_nettype wire

FILE: src/tali_deviation.sv
// ----------------------------------------------------------------------------
// tali_deviation
// cross products of targets and counts, registered with the open flags
// ----------------------------------------------------------------------------
`default_nettype none

module tali_deviation #(
	parameter int COUNT_BITS = tali_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic                    stop,
	input  wire logic [COUNT_BITS-1:0]   tgt_x,
	input  wire logic [COUNT_BITS-1:0]   tgt_y,
	input  wire logic [COUNT_BITS-1:0]   done_x,
	input  wire logic [COUNT_BITS-1:0]   done_y,
	output logic      [2*COUNT_BITS-1:0] k1,
	output logic      [2*COUNT_BITS-1:0] k2,
	output tali_pkg::flags_t             flags
);

	logic [2*COUNT_BITS-1:0] k1_s2;
	logic [2*COUNT_BITS-1:0] k2_s2;
	tali_pkg::flags_t        flags_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			k1_s2           <= (2*COUNT_BITS)'(tgt_x) * (2*COUNT_BITS)'(done_y);
			k2_s2           <= (2*COUNT_BITS)'(done_x) * (2*COUNT_BITS)'(tgt_y);
			flags_s2.stop   <= stop;
			flags_s2.x_open <= done_x < tgt_x;
			flags_s2.y_open <= done_y < tgt_y;
		end
	end

	assign k1    = k1_s2;
	assign k2    = k2_s2;
	assign flags = flags_s2;

endmodule

`default_nettype wire

FILE: src/two_axis_line_interpolator_unit.sv
// ----------------------------------------------------------------------------
// two_axis_line_interpolator_unit
// point-by-point comparison line interpolator for two stepper axes
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request, in order. Three registers sit between the ports: the
// step counters and request register, the register after the two
// cross-product multipliers, and the result register. The result register
// holds while the output handshake stalls; up to two more requests enter
// behind it before s_tready drops. Targets are written on the cfg port between
// moves; only their low COUNT_BITS bits count.
`default_nettype none

module two_axis_line_interpolator_unit #(
	parameter int COUNT_BITS = tali_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tali_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [tali_pkg::STEPS_BITS-1:0]     cfg_data,
	// requests
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [0] pulse_axis, [1] stop_request, rest zero
	input  wire logic [tali_pkg::S_TDATA_BITS-1:0]   s_tdata,
	// [0] opcode
	input  wire logic [tali_pkg::S_TUSER_BITS-1:0]   s_tuser,
	// results
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [0] enable_x, [1] enable_y, [2] aborted, rest zero
	output logic      [tali_pkg::M_TDATA_BITS-1:0]   m_tdata,
	// finished
	output logic                                     m_tlast
);

	localparam int SB = tali_pkg::STEPS_BITS;

	logic [SB-1:0]           steps_x_q;
	logic [SB-1:0]           steps_y_q;
	logic [COUNT_BITS+SB-1:0] ext_x;
	logic [COUNT_BITS+SB-1:0] ext_y;
	logic [COUNT_BITS-1:0]   tgt_x;
	logic [COUNT_BITS-1:0]   tgt_y;

	tali_pkg::item_t         item;
	logic                    accept;
	logic                    s1_free;
	logic                    s2_free;
	logic                    out_free;
	logic                    valid_s1;
	logic                    stop_s1;
	logic                    valid_s2;

	logic [COUNT_BITS-1:0]   done_x;
	logic [COUNT_BITS-1:0]   done_y;
	logic [2*COUNT_BITS-1:0] k1;
	logic [2*COUNT_BITS-1:0] k2;
	tali_pkg::flags_t        flags;

	logic                    x_first;
	logic                    en_x;
	logic                    en_y;
	logic                    fin;
	logic                    ab;

	logic                    out_valid_q;
	logic                    en_x_q;
	logic                    en_y_q;
	logic                    fin_q;
	logic                    ab_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_x_q <= '0;
			steps_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tali_pkg::cfg_reg_t'(cfg_index))
				tali_pkg::REG_STEPS_X: steps_x_q <= cfg_data;
				tali_pkg::REG_STEPS_Y: steps_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// targets cut or widened to the counter width
	assign ext_x = {{COUNT_BITS{1'b0}}, steps_x_q};
	assign ext_y = {{COUNT_BITS{1'b0}}, steps_y_q};
	assign tgt_x = ext_x[COUNT_BITS-1:0];
	assign tgt_y = ext_y[COUNT_BITS-1:0];

	// request unpacking and pipeline flow
	assign item.opcode       = tali_pkg::opcode_t'(s_tuser[0]);
	assign item.pulse_axis   = tali_pkg::axis_t'(s_tdata[0]);
	assign item.stop_request = s_tdata[1];

	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stop is ignored on a start request
	always_ff @(posedge clk) begin
		if (accept) begin
			stop_s1 <= (item.opcode == tali_pkg::OP_PULSE) && item.stop_request;
		end
	end

	tali_step_counter #(
		.COUNT_BITS (COUNT_BITS)
	) u_step_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.item   (item),
		.done_x (done_x),
		.done_y (done_y)
	);

	tali_deviation #(
		.COUNT_BITS (COUNT_BITS)
	) u_deviation (
		.clk    (clk),
		.en     (s2_free && valid_s1),
		.stop   (stop_s1),
		.tgt_x  (tgt_x),
		.tgt_y  (tgt_y),
		.done_x (done_x),
		.done_y (done_y),
		.k1     (k1),
		.k2     (k2),
		.flags  (flags)
	);

	// axis choice
	assign x_first = flags.x_open && (k1 >= k2);
	assign ab      = flags.stop;
	assign fin     = !flags.stop && !flags.x_open && !flags.y_open;
	assign en_x    = !flags.stop && x_first;
	assign en_y    = !flags.stop && !x_first && flags.y_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			en_x_q <= en_x;
			en_y_q <= en_y;
			fin_q  <= fin;
			ab_q   <= ab;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(tali_pkg::M_TDATA_BITS-3){1'b0}}, ab_q, en_y_q, en_x_q};
	assign m_tlast  = fin_q;

endmodule

`default_nettype wire
